FILE: rtl/assert_macros.svh
// Assertion helpers, clocked on clk with synchronous reset rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/urd_pkg.sv
`default_nettype none

package urd_pkg;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_SSW  = 2'd1,
    KIND_USW  = 2'd2,
    KIND_QSW  = 2'd3
  } kind_t;

  localparam int STORE_DEPTH = 25;

  localparam logic [23:0] HDR_SSW = 24'h535357;
  localparam logic [23:0] HDR_USW = 24'h555357;
  localparam logic [23:0] HDR_QSW = 24'h515357;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_E     = 8'h45;
  localparam logic [7:0] CHAR_N     = 8'h4E;
  localparam logic [7:0] CHAR_D     = 8'h44;

  typedef struct packed {
    kind_t        kind;
    logic         ok;
    logic [7:0]   resp_code;
    logic [7:0]   package_index;
    logic [63:0]  flags_low;
    logic [63:0]  flags_high;
    logic [15:0]  current_version;
    logic [15:0]  new_version;
    logic [7:0]   update_result;
  } res_t;

  // body length: data bytes plus the XOR byte
  function automatic logic [4:0] body_len(input kind_t kind);
    logic [4:0] n;
    unique case (kind)
      KIND_SSW: n = 5'd4;
      KIND_USW: n = 5'd3;
      default:  n = 5'd23;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/urd_core.sv
`default_nettype none

module urd_core
  import urd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       acc,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output res_t            res,
  output logic            res_valid
);

  `include "assert_macros.svh"

  logic [23:0] header_window;
  kind_t       active_kind;
  logic [4:0]  byte_position;
  logic [7:0]  running_xor;
  logic        buffer_done;
  logic [7:0]  store [STORE_DEPTH];

  kind_t       hit_kind;
  logic [4:0]  n;
  logic        complete;
  logic        ok;
  logic [7:0]  end_e;
  logic [7:0]  end_n;
  logic [127:0] flags;
  logic        collecting;

  always_comb begin
    hit_kind = KIND_NONE;
    if (data_byte == CHAR_COLON) begin
      priority if (header_window == HDR_SSW) hit_kind = KIND_SSW;
      else if (header_window == HDR_USW) hit_kind = KIND_USW;
      else if (header_window == HDR_QSW) hit_kind = KIND_QSW;
      else hit_kind = KIND_NONE;
    end
  end

  assign n          = body_len(active_kind);
  assign collecting = !buffer_done && (active_kind != KIND_NONE);
  assign complete   = collecting && (byte_position == n + 5'd2);

  always_comb begin
    unique case (active_kind)
      KIND_SSW: begin
        end_e = store[4];
        end_n = store[5];
      end
      KIND_USW: begin
        end_e = store[3];
        end_n = store[4];
      end
      default: begin
        end_e = store[23];
        end_n = store[24];
      end
    endcase
  end

  assign ok = complete && (running_xor == 8'h00) && (end_e == CHAR_E) &&
              (end_n == CHAR_N) && (data_byte == CHAR_D);

  // package k sits MSB first in data byte 1 + k/8
  for (genvar k = 0; k < 128; k++) begin : g_flag
    assign flags[k] = store[1 + k / 8][7 - k % 8];
  end

  always_comb begin
    res = '0;
    res_valid = acc && (complete || (last_byte && !buffer_done));
    if (active_kind == KIND_NONE) begin
      res.kind = hit_kind;
    end else begin
      res.kind = active_kind;
    end
    if (ok) begin
      res.ok = 1'b1;
      unique case (active_kind)
        KIND_SSW: res.resp_code = store[0];
        KIND_USW: begin
          res.package_index = store[0];
          res.resp_code     = store[1];
        end
        default: begin
          res.resp_code       = store[0];
          res.flags_low       = flags[63:0];
          res.flags_high      = flags[127:64];
          res.current_version = {store[17], store[18]};
          res.new_version     = {store[19], store[20]};
          res.update_result   = store[21];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc && collecting && (byte_position < 5'(STORE_DEPTH))) begin
      store[byte_position] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_window <= '0;
      active_kind   <= KIND_NONE;
      byte_position <= '0;
      running_xor   <= '0;
      buffer_done   <= 1'b0;
    end else if (acc) begin
      if (last_byte) begin
        header_window <= '0;
        active_kind   <= KIND_NONE;
        byte_position <= '0;
        running_xor   <= '0;
        buffer_done   <= 1'b0;
      end else if (!buffer_done) begin
        if (active_kind == KIND_NONE) begin
          header_window <= {header_window[15:0], data_byte};
          if (hit_kind != KIND_NONE) begin
            active_kind   <= hit_kind;
            byte_position <= '0;
            running_xor   <= '0;
          end
        end else begin
          if (byte_position < n) running_xor <= running_xor ^ data_byte;
          byte_position <= byte_position + 5'd1;
          if (complete) buffer_done <= 1'b1;
        end
      end
    end
  end

  `ASSERT_CLK(a_done_has_kind, buffer_done |-> active_kind != KIND_NONE,
              "buffer done without a frame kind")
  `ASSERT_CLK(a_pos_in_frame,
              collecting |-> byte_position <= n + 5'd2,
              "byte position past end of frame")
  `ASSERT_CLK(a_ok_only_complete, res.ok |-> complete,
              "frame ok outside of frame completion")

endmodule

`default_nettype wire

FILE: rtl/urd_out_reg.sv
`default_nettype none

module urd_out_reg
  import urd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic res_valid,
  input  wire res_t res,
  output logic      ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_res
);

  `include "assert_macros.svh"

  assign ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && res_valid) begin
      out_res <= res;
    end
  end

  `ASSERT_CLK(a_no_overwrite, res_valid |-> ready,
              "result produced while output register is held")

endmodule

`default_nettype wire

FILE: rtl/update_response_deframer_top.sv
// Update response deframer.
// Input channel: one buffer byte per item (data_byte, last_byte marks the
// buffer's final byte) on in_valid / in_ready.
// Output channel: one result per buffer on out_valid / out_ready, carrying
// frame_kind, frame_ok, resp_code, package_index, flags_low / flags_high,
// current_version, new_version and update_result.
// The first SSW:, USW: or QSW: header is framed; the result appears on the
// cycle after the byte that completes the frame (third END byte) or after
// the last byte if no complete frame was seen. Later bytes of the same
// buffer are consumed silently.
// Throughput: 1 byte per cycle; the output register frees the input side
// as soon as the result is taken or in the same cycle it is taken.
// When the receiver stalls with a result pending, in_ready drops until
// out_ready returns.
// Reset (rst, synchronous) clears the search state and the output valid;
// any accepted last byte also returns the search state to its reset values.
`default_nettype none

module update_response_deframer_top
  import urd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       frame_kind,
  output logic             frame_ok,
  output logic [7:0]       resp_code,
  output logic [7:0]       package_index,
  output logic [63:0]      flags_low,
  output logic [63:0]      flags_high,
  output logic [15:0]      current_version,
  output logic [15:0]      new_version,
  output logic [7:0]       update_result
);

  res_t res;
  res_t out_res;
  logic res_valid;
  logic acc;

  assign acc = in_valid && in_ready;

  urd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .res       (res),
    .res_valid (res_valid)
  );

  urd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .ready     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign frame_kind      = out_res.kind;
  assign frame_ok        = out_res.ok;
  assign resp_code       = out_res.resp_code;
  assign package_index   = out_res.package_index;
  assign flags_low       = out_res.flags_low;
  assign flags_high      = out_res.flags_high;
  assign current_version = out_res.current_version;
  assign new_version     = out_res.new_version;
  assign update_result   = out_res.update_result;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import urd_pkg::*;

  localparam int BYTE_TARGET = 1900;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 10;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS, FILL_ALT} fill_t;

  class frame_scoreboard;
    logic [23:0] win;
    kind_t       kind;
    logic [4:0]  pos;
    logic [7:0]  xsum;
    logic [7:0]  body [26];
    bit          done;
    res_t        pending[$];
    int          errors;
    int          results;
    int          good [4];

    function new();
      clear();
      errors = 0;
      results = 0;
      good = '{0, 0, 0, 0};
    endfunction

    static function int frame_len(kind_t k);
      case (k)
        KIND_SSW: return 4;
        KIND_USW: return 3;
        default:  return 23;
      endcase
    endfunction

    function void clear();
      win = '0;
      kind = KIND_NONE;
      pos = '0;
      xsum = '0;
      done = 1'b0;
    endfunction

    function res_t blank_result(kind_t k);
      res_t r;
      r = '0;
      r.kind = k;
      return r;
    endfunction

    function res_t frame_result();
      res_t r;
      int   n;
      int   k;
      bit   ok;
      n = frame_len(kind);
      r = blank_result(kind);
      ok = (xsum == 8'h00) && body[n] == CHAR_E && body[n + 1] == CHAR_N &&
           body[n + 2] == CHAR_D;
      if (!ok) return r;
      r.ok = 1'b1;
      case (kind)
        KIND_SSW: r.resp_code = body[0];
        KIND_USW: begin
          r.package_index = body[0];
          r.resp_code = body[1];
        end
        default: begin
          r.resp_code = body[0];
          for (k = 0; k < 128; k++) begin
            if (body[1 + k / 8][7 - k % 8]) begin
              if (k < 64) r.flags_low[k] = 1'b1;
              else r.flags_high[k - 64] = 1'b1;
            end
          end
          r.current_version = {body[17], body[18]};
          r.new_version = {body[19], body[20]};
          r.update_result = body[21];
        end
      endcase
      return r;
    endfunction

    // returns 1 if the byte was consumed (not ignored after a result)
    function bit note_byte(logic [7:0] b, bit l);
      bit used;
      int n;
      used = !done;
      if (done) begin
      end else if (kind == KIND_NONE) begin
        if (b == CHAR_COLON) begin
          if (win == HDR_SSW) kind = KIND_SSW;
          else if (win == HDR_USW) kind = KIND_USW;
          else if (win == HDR_QSW) kind = KIND_QSW;
        end
        if (kind != KIND_NONE) begin
          pos = '0;
          xsum = '0;
        end
        win = {win[15:0], b};
      end else begin
        n = frame_len(kind);
        if (pos < 26) body[pos] = b;
        if (pos < n) xsum ^= b;
        pos = pos + 5'd1;
        if (int'(pos) >= n + 3) begin
          pending.push_back(frame_result());
          done = 1'b1;
        end
      end
      if (l) begin
        if (!done) pending.push_back(blank_result(kind));
        clear();
      end
      return used;
    endfunction

    function void cmp(string name, logic [63:0] expv, logic [63:0] got);
      if (got !== expv) begin
        $error("%s: expected %0h, got %0h", name, expv, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        $error("result with no frame pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      results++;
      if (e.ok) good[e.kind]++;
      cmp("frame_kind", 64'(e.kind), 64'(got.kind));
      cmp("frame_ok", 64'(e.ok), 64'(got.ok));
      cmp("resp_code", 64'(e.resp_code), 64'(got.resp_code));
      cmp("package_index", 64'(e.package_index), 64'(got.package_index));
      cmp("flags_low", e.flags_low, got.flags_low);
      cmp("flags_high", e.flags_high, got.flags_high);
      cmp("current_version", 64'(e.current_version), 64'(got.current_version));
      cmp("new_version", 64'(e.new_version), 64'(got.new_version));
      cmp("update_result", 64'(e.update_result), 64'(got.update_result));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  frame_kind;
  logic        frame_ok;
  logic [7:0]  resp_code;
  logic [7:0]  package_index;
  logic [63:0] flags_low;
  logic [63:0] flags_high;
  logic [15:0] current_version;
  logic [15:0] new_version;
  logic [7:0]  update_result;

  frame_scoreboard sb;
  logic [7:0]      frame_bytes[$];
  bit              calm;
  int              total_bytes;
  int              used_bytes;
  int              idle_cycles;
  int              stall_left;

  update_response_deframer_top dut (.*);

  always #2 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void push_noise();
    case ($urandom_range(0, 9))
      5: frame_bytes.push_back("S");
      6: frame_bytes.push_back("U");
      7: frame_bytes.push_back("Q");
      8: frame_bytes.push_back("W");
      9: frame_bytes.push_back(CHAR_COLON);
      default: frame_bytes.push_back(8'($urandom));
    endcase
  endfunction

  function automatic void push_header(kind_t k);
    logic [23:0] h;
    case (k)
      KIND_SSW: h = HDR_SSW;
      KIND_USW: h = HDR_USW;
      default:  h = HDR_QSW;
    endcase
    frame_bytes.push_back(h[23:16]);
    frame_bytes.push_back(h[15:8]);
    frame_bytes.push_back(h[7:0]);
    frame_bytes.push_back(CHAR_COLON);
  endfunction

  function automatic void push_frame(kind_t k, fill_t f, bit bad_xor, bit bad_end);
    int         n;
    int         i;
    logic [7:0] x;
    logic [7:0] v;
    logic [7:0] trailer [3];
    n = frame_scoreboard::frame_len(k);
    x = '0;
    trailer = '{CHAR_E, CHAR_N, CHAR_D};
    for (i = 0; i < n - 1; i++) begin
      case (f)
        FILL_ONES:  v = 8'hFF;
        FILL_ZEROS: v = 8'h00;
        FILL_ALT:   v = i[0] ? 8'h55 : 8'hAA;
        default:    v = 8'($urandom);
      endcase
      frame_bytes.push_back(v);
      x ^= v;
    end
    if (bad_xor) x ^= 8'($urandom_range(1, 255));
    frame_bytes.push_back(x);
    if (bad_end) trailer[$urandom_range(0, 2)] ^= 8'($urandom_range(1, 255));
    for (i = 0; i < 3; i++) frame_bytes.push_back(trailer[i]);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit l);
    int gap;
    if (!in_valid) in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    total_bytes++;
    if (sb.note_byte(b, l)) used_bytes++;
    gap = calm ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_buffer();
    int i;
    for (i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    frame_bytes.delete();
  endtask

  task automatic wait_results();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic random_buffer();
    int    r;
    kind_t k;
    r = $urandom_range(0, 99);
    k = kind_t'($urandom_range(1, 3));
    calm = ($urandom_range(0, 9) == 0);
    if (r >= 75 && r < 85) begin
      repeat ($urandom_range(1, 12)) push_noise();
    end else begin
      repeat ($urandom_range(0, 6)) push_noise();
      push_header(k);
      if (r < 65) begin
        push_frame(k, FILL_RANDOM, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
      end else if (r < 75) begin
        // cut off, possibly right at the colon
        push_frame(k, FILL_RANDOM, 1'b0, 1'b0);
        repeat ($urandom_range(1, frame_scoreboard::frame_len(k) + 3))
          void'(frame_bytes.pop_back());
      end else begin
        push_frame(k, fill_t'($urandom_range(1, 3)), 1'b0, 1'b0);
      end
      if (r < 65 || r >= 85)
        repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom));
    end
    send_buffer();
    if ($urandom_range(0, 11) == 0) wait_results();
  endtask

  always @(posedge clk) begin : out_side
    res_t seen;
    if (!rst && out_valid && out_ready) begin
      seen = '{kind: kind_t'(frame_kind), ok: frame_ok, resp_code: resp_code,
               package_index: package_index, flags_low: flags_low,
               flags_high: flags_high, current_version: current_version,
               new_version: new_version, update_result: update_result};
      sb.check_result(seen);
    end
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      out_ready <= ($urandom_range(0, 2) != 0);
      stall_left = gap_len();
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
      $display("** update_response_deframer_top: FAILED **");
      $finish;
    end
  end

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    last_byte = 1'b0;
    calm = 1'b0;
    stall_left = 0;
    idle_cycles = 0;
    total_bytes = 0;
    used_bytes = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // zero byte alone: no header
    frame_bytes.push_back(8'h00);
    send_buffer();
    // buffer ends on the header colon
    push_header(KIND_USW);
    send_buffer();
    // good SSW, all ones, last flag on the final END byte
    push_header(KIND_SSW);
    push_frame(KIND_SSW, FILL_ONES, 1'b0, 1'b0);
    send_buffer();
    // USW with a bad check byte
    push_header(KIND_USW);
    push_frame(KIND_USW, FILL_ZEROS, 1'b1, 1'b0);
    send_buffer();
    wait_results();

    while (total_bytes < BYTE_TARGET) random_buffer();
    calm = 1'b0;
    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d bytes sent, %0d of them ignored after a result; %0d results checked",
             total_bytes, total_bytes - used_bytes, sb.results);
    $display("good frames: SSW %0d, USW %0d, QSW %0d; %0d mismatches",
             sb.good[KIND_SSW], sb.good[KIND_USW], sb.good[KIND_QSW], sb.errors);
    if (sb.errors == 0) begin
      $display("** update_response_deframer_top: PASSED **");
    end else begin
      $display("** update_response_deframer_top: FAILED **");
    end
    $finish;
  end

endmodule
